// ----- sv/qaar_pkg.sv -----
// Shared constants, defaults and the CORDIC arctangent table for the
// quaternion axis-angle rotator. No dependencies.
package qaar_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int ANGLE_WIDTH_DEF     = 16;

    // CORDIC works in Q1.30 with 2^32 angle units per turn.
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam int ANGLE_Z_W    = 33;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

    function automatic logic [31:0] atan_step(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2F9;
            15:      v = 32'h0000517C;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A2F;
            19:      v = 32'h00000517;
            20:      v = 32'h0000028B;
            21:      v = 32'h00000145;
            22:      v = 32'h000000A2;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/qaar_in_if.sv -----
// Input channel of the quaternion rotator: valid/ready plus one item.
// Depends on qaar_pkg for default widths.
interface qaar_in_if #(
    parameter int COMPONENT_WIDTH = qaar_pkg::COMPONENT_WIDTH_DEF,
    parameter int ANGLE_WIDTH     = qaar_pkg::ANGLE_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] quat_x;
    logic signed [COMPONENT_WIDTH-1:0] quat_y;
    logic signed [COMPONENT_WIDTH-1:0] quat_z;
    logic signed [COMPONENT_WIDTH-1:0] quat_w;
    logic        [ANGLE_WIDTH-1:0]     turn_angle;
    logic signed [COMPONENT_WIDTH-1:0] axis_x;
    logic signed [COMPONENT_WIDTH-1:0] axis_y;
    logic signed [COMPONENT_WIDTH-1:0] axis_z;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, turn_angle, axis_x, axis_y, axis_z,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, turn_angle, axis_x, axis_y, axis_z,
        output ready
    );
endinterface

// ----- sv/qaar_out_if.sv -----
// Result channel of the quaternion rotator: valid/ready plus one item.
// Depends on qaar_pkg for the default width.
interface qaar_out_if #(
    parameter int COMPONENT_WIDTH = qaar_pkg::COMPONENT_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] rot_x;
    logic signed [COMPONENT_WIDTH-1:0] rot_y;
    logic signed [COMPONENT_WIDTH-1:0] rot_z;
    logic signed [COMPONENT_WIDTH-1:0] rot_w;
    logic                              clipped;

    modport source (
        output valid, rot_x, rot_y, rot_z, rot_w, clipped,
        input  ready
    );
    modport sink (
        input  valid, rot_x, rot_y, rot_z, rot_w, clipped,
        output ready
    );
endinterface

// ----- sv/qaar_delay.sv -----
// Enabled shift line that carries side data alongside the pipeline.
// No package dependencies.
module qaar_delay #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] stage_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                stage_reg[k] <= stage_reg[k-1];
            end
        end
    end

    assign q = stage_reg[DEPTH-1];
endmodule

// ----- sv/qaar_cordic.sv -----
// Fully pipelined rotation-mode CORDIC giving sin and cos of the half angle.
// One step per register stage plus a rounding stage. Depends on qaar_pkg.
module qaar_cordic #(
    parameter int COMPONENT_WIDTH = qaar_pkg::COMPONENT_WIDTH_DEF,
    parameter int ANGLE_WIDTH     = qaar_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [ANGLE_WIDTH-1:0]          angle,
    output logic                            out_valid,
    output logic signed [COMPONENT_WIDTH:0] sin_half,
    output logic signed [COMPONENT_WIDTH:0] cos_half
);
    localparam int STEPS = qaar_pkg::CORDIC_STEPS;
    localparam int XW    = qaar_pkg::CORDIC_W;
    localparam int ZW    = qaar_pkg::ANGLE_Z_W;
    localparam int ZSH   = 31 - ANGLE_WIDTH;
    localparam int SH    = 32 - COMPONENT_WIDTH;

    logic signed [XW-1:0] x_reg [STEPS];
    logic signed [XW-1:0] y_reg [STEPS];
    logic signed [ZW-1:0] z_reg [STEPS];
    logic                 upper_reg [STEPS];
    logic                 valid_reg [STEPS];

    genvar k;
    for (k = 0; k < STEPS; k++)
    begin : g_step
        logic signed [XW-1:0] x_in, y_in, x_next, y_next;
        logic signed [ZW-1:0] z_in, z_next;
        logic                 up_in, v_in;

        if (k == 0)
        begin : g_first
            // The upper half of the turn maps onto the lower one by a quarter-turn swap.
            assign x_in  = qaar_pkg::CORDIC_GAIN;
            assign y_in  = '0;
            assign z_in  = $signed(ZW'(angle[ANGLE_WIDTH-2:0]) << ZSH);
            assign up_in = angle[ANGLE_WIDTH-1];
            assign v_in  = in_valid;
        end
        else
        begin : g_rest
            assign x_in  = x_reg[k-1];
            assign y_in  = y_reg[k-1];
            assign z_in  = z_reg[k-1];
            assign up_in = upper_reg[k-1];
            assign v_in  = valid_reg[k-1];
        end

        always_comb
        begin
            if (z_in >= 0)
            begin
                x_next = x_in - (y_in >>> k);
                y_next = y_in + (x_in >>> k);
                z_next = z_in - $signed(ZW'(qaar_pkg::atan_step(k)));
            end
            else
            begin
                x_next = x_in + (y_in >>> k);
                y_next = y_in - (x_in >>> k);
                z_next = z_in + $signed(ZW'(qaar_pkg::atan_step(k)));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]     <= x_next;
                y_reg[k]     <= y_next;
                z_reg[k]     <= z_next;
                upper_reg[k] <= up_in;
            end
        end
    end

    logic signed [XW-1:0]          x_frac, y_frac;
    logic signed [COMPONENT_WIDTH:0] sin_next, cos_next;
    logic signed [COMPONENT_WIDTH:0] sin_reg, cos_reg;
    logic                            out_valid_reg;

    if (SH == 0)
    begin : g_noround
        assign x_frac = x_reg[STEPS-1];
        assign y_frac = y_reg[STEPS-1];
    end
    else
    begin : g_round
        localparam logic signed [XW-1:0] HALF = XW'(1) << (SH - 1);
        assign x_frac = (x_reg[STEPS-1] + HALF) >>> SH;
        assign y_frac = (y_reg[STEPS-1] + HALF) >>> SH;
    end

    always_comb
    begin
        if (upper_reg[STEPS-1])
        begin
            sin_next = (COMPONENT_WIDTH+1)'(x_frac);
            cos_next = (COMPONENT_WIDTH+1)'(-y_frac);
        end
        else
        begin
            sin_next = (COMPONENT_WIDTH+1)'(y_frac);
            cos_next = (COMPONENT_WIDTH+1)'(x_frac);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sin_half  = sin_reg;
    assign cos_half  = cos_reg;
endmodule

// ----- sv/qaar_hamilton.sv -----
// Two-stage pipelined Hamilton product a*b with per-product rounding.
// Stage one holds the sixteen products, stage two the rounded sums. No dependencies.
module qaar_hamilton #(
    parameter int OPW  = 17,
    parameter int FRAC = 14,
    localparam int SW  = 2 * OPW + 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [OPW-1:0] a [4],
    input  logic signed [OPW-1:0] b [4],
    output logic                  out_valid,
    output logic signed [SW-1:0]  o [4]
);
    localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC - 1);

    logic signed [2*OPW-1:0] prod_reg [4][4];
    logic                    valid1_reg;
    logic signed [SW-1:0]    rnd [4][4];
    logic signed [SW-1:0]    o_next [4];
    logic signed [SW-1:0]    o_reg [4];
    logic                    valid2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[i][j] <= a[i] * b[j];
                end
            end
            o_reg <= o_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                rnd[i][j] = (SW'(prod_reg[i][j]) + HALF) >>> FRAC;
            end
        end
        o_next[0] = rnd[3][0] + rnd[0][3] + rnd[1][2] - rnd[2][1];
        o_next[1] = rnd[3][1] - rnd[0][2] + rnd[1][3] + rnd[2][0];
        o_next[2] = rnd[3][2] + rnd[0][1] - rnd[1][0] + rnd[2][3];
        o_next[3] = rnd[3][3] - rnd[0][0] - rnd[1][1] - rnd[2][2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    assign out_valid = valid2_reg;
    assign o         = o_reg;
endmodule

// ----- sv/quaternion_axis_angle_rotate_top.sv -----
// Top level of the quaternion axis-angle rotator: rotor, r*q and (r*q)*conj(r).
// Depends on qaar_pkg, qaar_in_if, qaar_out_if, qaar_cordic, qaar_hamilton, qaar_delay.
//
// Channel   Role    Item contents
// --------  ------  ---------------------------------------------------------
// operand   sink    quat_x, quat_y, quat_z, quat_w, turn_angle, axis_x/y/z
// result    source  rot_x, rot_y, rot_z, rot_w, clipped
//
// One item is accepted per cycle while the result side is not stalling; each item passes from
// acceptance to the result register through the half-angle CORDIC (one step per stage
// plus rounding), the rotor registers, each Hamilton product and each clamp's register.
// Reset clears only the valid bits; nothing is kept between items.
// The whole pipeline advances together whenever the result register is empty or
// being taken, so a stall on the result side freezes every stage in place.
module quaternion_axis_angle_rotate_top #(
    parameter int COMPONENT_WIDTH = qaar_pkg::COMPONENT_WIDTH_DEF,
    parameter int ANGLE_WIDTH     = qaar_pkg::ANGLE_WIDTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    qaar_in_if.sink    operand,
    qaar_out_if.source result
);
    localparam int W          = COMPONENT_WIDTH;
    localparam int FRAC       = W - 2;
    localparam int RW         = W + 1;
    localparam int PW         = 2 * W + 1;
    localparam int SW         = 2 * RW + 3;
    localparam int CORDIC_LAT = qaar_pkg::CORDIC_STEPS + 1;

    localparam logic signed [PW:0]   ROTOR_HALF = (PW+1)'(1) << (FRAC - 1);
    localparam logic signed [SW-1:0] BIG        = (SW'(1) << W) - SW'(1);
    localparam logic signed [SW-1:0] NEG_BIG    = -BIG;
    localparam logic signed [SW-1:0] OUT_HI     = (SW'(1) << (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] OUT_LO     = -(SW'(1) << (W - 1));

    // A single enable moves every stage; ready follows it.
    logic en;
    logic result_valid_reg;

    assign en            = !result_valid_reg || result.ready;
    assign operand.ready = en;

    // Half-angle sine and cosine.
    logic                 cs_valid;
    logic signed [RW-1:0] sin_half, cos_half;

    qaar_cordic #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH),
        .ANGLE_WIDTH     (ANGLE_WIDTH)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (operand.valid),
        .angle     (operand.turn_angle),
        .out_valid (cs_valid),
        .sin_half  (sin_half),
        .cos_half  (cos_half)
    );

    // The axis waits for the CORDIC; the quaternion waits for the rotor as well.
    logic [3*W-1:0] axis_d;
    logic [4*W-1:0] quat_d;

    qaar_delay #(.WIDTH(3 * W), .DEPTH(CORDIC_LAT)) u_axis_dly (
        .clk (clk),
        .en  (en),
        .d   ({operand.axis_z, operand.axis_y, operand.axis_x}),
        .q   (axis_d)
    );

    qaar_delay #(.WIDTH(4 * W), .DEPTH(CORDIC_LAT + 2)) u_quat_dly (
        .clk (clk),
        .en  (en),
        .d   ({operand.quat_w, operand.quat_z, operand.quat_y, operand.quat_x}),
        .q   (quat_d)
    );

    // Rotor: vector part is the axis scaled by the half-angle sine, rounded.
    logic signed [PW-1:0] prod_a_reg [3];
    logic signed [RW-1:0] cos_a_reg;
    logic                 va_reg;
    logic signed [RW-1:0] r_reg [3];
    logic signed [RW-1:0] rw_reg;
    logic                 vb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_a_reg[k] <= $signed(axis_d[k*W +: W]) * sin_half;
                r_reg[k]      <= RW'(((PW+1)'(prod_a_reg[k]) + ROTOR_HALF) >>> FRAC);
            end
            cos_a_reg <= cos_half;
            rw_reg    <= cos_a_reg;
        end
    end

    // First product r*q.
    logic signed [RW-1:0] h1_a [4];
    logic signed [RW-1:0] h1_b [4];
    logic signed [SW-1:0] h1_o [4];
    logic                 h1_valid;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            h1_a[k] = r_reg[k];
        end
        h1_a[3] = rw_reg;
        for (int k = 0; k < 4; k++)
        begin
            h1_b[k] = RW'($signed(quat_d[k*W +: W]));
        end
    end

    qaar_hamilton #(.OPW(RW), .FRAC(FRAC)) u_ham_rq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vb_reg),
        .a         (h1_a),
        .b         (h1_b),
        .out_valid (h1_valid),
        .o         (h1_o)
    );

    // Intermediate clamp to one bit beyond the component range.
    logic signed [RW-1:0] t_reg [4];
    logic signed [RW-1:0] t_next [4];
    logic                 clip1_reg, clip1_next;
    logic                 vc1_reg;

    always_comb
    begin
        clip1_next = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (h1_o[k] > BIG)
            begin
                t_next[k]  = RW'(BIG);
                clip1_next = 1'b1;
            end
            else if (h1_o[k] < NEG_BIG)
            begin
                t_next[k]  = RW'(NEG_BIG);
                clip1_next = 1'b1;
            end
            else
            begin
                t_next[k] = RW'(h1_o[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= t_next;
            clip1_reg <= clip1_next;
        end
    end

    // The conjugate rotor is brought level with the clamped r*q.
    logic [4*RW-1:0] rotor_d;
    logic            clip1_d;

    qaar_delay #(.WIDTH(4 * RW), .DEPTH(3)) u_rotor_dly (
        .clk (clk),
        .en  (en),
        .d   ({rw_reg, r_reg[2], r_reg[1], r_reg[0]}),
        .q   (rotor_d)
    );

    qaar_delay #(.WIDTH(1), .DEPTH(2)) u_clip_dly (
        .clk (clk),
        .en  (en),
        .d   (clip1_reg),
        .q   (clip1_d)
    );

    // Second product (r*q)*conj(r).
    logic signed [RW-1:0] h2_b [4];
    logic signed [SW-1:0] h2_o [4];
    logic                 h2_valid;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            h2_b[k] = -$signed(rotor_d[k*RW +: RW]);
        end
        h2_b[3] = $signed(rotor_d[3*RW +: RW]);
    end

    qaar_hamilton #(.OPW(RW), .FRAC(FRAC)) u_ham_rc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vc1_reg),
        .a         (t_reg),
        .b         (h2_b),
        .out_valid (h2_valid),
        .o         (h2_o)
    );

    // Final saturation into the result register.
    logic signed [W-1:0] rot_reg [4];
    logic signed [W-1:0] rot_next [4];
    logic                clip_reg, clip_next;

    always_comb
    begin
        clip_next = clip1_d;
        for (int k = 0; k < 4; k++)
        begin
            if (h2_o[k] > OUT_HI)
            begin
                rot_next[k] = W'(OUT_HI);
                clip_next   = 1'b1;
            end
            else if (h2_o[k] < OUT_LO)
            begin
                rot_next[k] = W'(OUT_LO);
                clip_next   = 1'b1;
            end
            else
            begin
                rot_next[k] = W'(h2_o[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg  <= rot_next;
            clip_reg <= clip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg           <= 1'b0;
            vb_reg           <= 1'b0;
            vc1_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg           <= cs_valid;
            vb_reg           <= va_reg;
            vc1_reg          <= h1_valid;
            result_valid_reg <= h2_valid;
        end
    end

    assign result.valid   = result_valid_reg;
    assign result.rot_x   = rot_reg[0];
    assign result.rot_y   = rot_reg[1];
    assign result.rot_z   = rot_reg[2];
    assign result.rot_w   = rot_reg[3];
    assign result.clipped = clip_reg;

    // A finished item in the last Hamilton stage reaches the result register on the next move.
    a_h2_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (h2_valid && en) |=> result.valid)
        else $error("item from second product did not reach the result register");

    // A result can only appear if the stage before it held an item.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(h2_valid))
        else $error("result appeared without an item behind it");

    // While a result waits, no new item enters.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !operand.ready)
        else $error("input accepted while the pipeline is stalled");
endmodule
